@@ rtl/csmac_pkg.sv @@
// Package for the carrier-sense access controller: state and function codes, register
// indexes, reset values and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package csmac_pkg;

  // Access state of the medium as it is reported in state_code.
  typedef enum logic [2:0] {
    ACC_INIT      = 3'd0,
    ACC_BUSY      = 3'd1,
    ACC_BUSY_PEND = 3'd2,
    ACC_IDLE      = 3'd3,
    ACC_IDLE_PEND = 3'd4
  } acc_state_t;

  // Kind of an input word.
  localparam logic [1:0] FN_RSSI = 2'd0;
  localparam logic [1:0] FN_POLL = 2'd1;
  localparam logic [1:0] FN_TICK = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BUSY_THR = 2'd0;
  localparam logic [1:0] CFG_TX_PROB  = 2'd1;
  localparam logic [1:0] CFG_WAIT_LO  = 2'd2;
  localparam logic [1:0] CFG_WAIT_HI  = 2'd3;

  localparam logic [7:0]  RST_BUSY_THR = 8'd128;
  localparam logic [6:0]  RST_TX_PROB  = 7'd50;
  localparam logic [15:0] RST_WAIT_LO  = 16'd10;
  localparam logic [15:0] RST_WAIT_HI  = 16'd100;

  // Modulus of the probability draw and its reciprocal: a 15-bit value times DRAW_RECIP,
  // shifted right by 19, gives the exact quotient by DRAW_MOD.
  localparam logic [14:0] DRAW_MOD   = 15'd101;
  localparam logic [12:0] DRAW_RECIP = 13'd5191;

  // Number of dividend bits handled by the remainder unit, one per cycle.
  localparam int unsigned RAND_W = 15;
  localparam int unsigned CNT_W  = $clog2(RAND_W);

  // Sequencer states.
  typedef enum logic [2:0] {
    C_IDLE,
    C_EVAL,
    C_DRAW,
    C_BACK,
    C_DONE
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // register the accepted input word
    logic apply;       // apply the single-step state update
    logic start_draw;  // start rand_draw mod 101
    logic start_back;  // start rand_backoff mod span
    logic grant;       // probability draw passed: send now
    logic load_back;   // load the new backoff period and clear elapsed time
    logic load_out;    // register the result word
  } csmac_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_back;   // sample frees the medium while a send is pending
    logic need_draw;   // poll with expired backoff
    logic div_done;    // backoff remainder is ready
    logic draw_done;   // draw remainder is ready
    logic draw_pass;   // send percentage exceeds the draw
  } csmac_sts_t;

endpackage

`default_nettype wire

@@ rtl/csmac_mod.sv @@
// Iterative remainder unit: one dividend bit per cycle, restoring form.
// Depends on csmac_pkg for the operand width and counter width.
`default_nettype none

module csmac_mod (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [csmac_pkg::RAND_W-1:0] dividend,
  input  wire logic [16:0]                  divisor,
  output logic                              done,
  output logic [16:0]                       remainder
);

  logic [16:0]                  rem_r, rem_nxt;
  logic [csmac_pkg::RAND_W-1:0] dvd_r, dvd_nxt;
  logic [16:0]                  div_r, div_nxt;
  logic [csmac_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [17:0]                  trial;
  logic [17:0]                  diff;

  assign trial = {rem_r, dvd_r[csmac_pkg::RAND_W-1]};
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      div_nxt  = divisor;
      cnt_nxt  = csmac_pkg::CNT_W'(csmac_pkg::RAND_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // Subtract when the partial remainder reaches the divisor.
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = diff[16:0];
      end else begin
        rem_nxt = trial[16:0];
      end
      dvd_nxt = {dvd_r[csmac_pkg::RAND_W-2:0], 1'b0};
      cnt_nxt = cnt_r - csmac_pkg::CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

@@ rtl/csmac_dp.sv @@
// Datapath of the access controller: configuration registers, captured word,
// access state, backoff timer, draw and remainder units and result register.
// Depends on csmac_pkg and csmac_mod.
`default_nettype none

module csmac_dp (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [15:0]           cfg_wdata,
  input  wire logic [1:0]            in_func,
  input  wire logic [7:0]            in_rssi,
  input  wire logic [14:0]           in_rand_draw,
  input  wire logic [14:0]           in_rand_backoff,
  input  wire csmac_pkg::csmac_cmd_t cmd,
  output csmac_pkg::csmac_sts_t      sts,
  output logic [7:0]                 out_data
);

  logic [7:0]  thr_r;
  logic [6:0]  prob_r;
  logic [15:0] lo_r;
  logic [15:0] hi_r;

  logic [1:0]  func_r;
  logic [7:0]  rssi_r;
  logic [14:0] rdraw_r;
  logic [14:0] rback_r;

  csmac_pkg::acc_state_t acc_r, acc_nxt;
  logic [15:0] period_r, period_nxt;
  logic [16:0] elapsed_r, elapsed_nxt;
  logic        tx_r, tx_nxt;
  logic [7:0]  out_r;

  logic        busy_c;
  logic        expired_c;
  logic [16:0] span_c;
  logic        div_done;
  logic [16:0] rem;
  logic        chan_busy_c;

  logic [27:0] draw_prod_r;
  logic [8:0]  draw_quot_c;
  logic [14:0] draw_rem_full_c;
  logic [6:0]  draw_rem_r;
  logic        draw_v1_r;
  logic        draw_v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= csmac_pkg::RST_BUSY_THR;
      prob_r <= csmac_pkg::RST_TX_PROB;
      lo_r   <= csmac_pkg::RST_WAIT_LO;
      hi_r   <= csmac_pkg::RST_WAIT_HI;
    end else if (cfg_we) begin
      unique case (cfg_index)
        csmac_pkg::CFG_BUSY_THR: thr_r  <= cfg_wdata[7:0];
        csmac_pkg::CFG_TX_PROB:  prob_r <= cfg_wdata[6:0];
        csmac_pkg::CFG_WAIT_LO:  lo_r   <= cfg_wdata;
        csmac_pkg::CFG_WAIT_HI:  hi_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r  <= in_func;
      rssi_r  <= in_rssi;
      rdraw_r <= in_rand_draw;
      rback_r <= in_rand_backoff;
    end
  end

  assign busy_c    = (rssi_r >= thr_r);
  assign expired_c = (elapsed_r > {1'b0, period_r});
  assign span_c    = {1'b0, hi_r} - {1'b0, lo_r} + 17'd1;

  // The backoff span varies with the registers, so it goes through the serial unit.
  csmac_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.start_back),
    .dividend  (rback_r),
    .divisor   (span_c),
    .done      (div_done),
    .remainder (rem)
  );

  // The draw is by a fixed modulus: a reciprocal product is registered, and in the next cycle
  // the quotient is taken from its upper bits and the remainder is formed and registered.
  assign draw_quot_c     = draw_prod_r[27:19];
  assign draw_rem_full_c = rdraw_r - {6'd0, draw_quot_c} * csmac_pkg::DRAW_MOD;

  always_ff @(posedge clk) begin
    draw_prod_r <= {13'd0, rdraw_r} * {15'd0, csmac_pkg::DRAW_RECIP};
    draw_rem_r  <= draw_rem_full_c[6:0];
    if (!rst_n) begin
      draw_v1_r <= 1'b0;
      draw_v2_r <= 1'b0;
    end else begin
      draw_v1_r <= cmd.start_draw;
      draw_v2_r <= draw_v1_r;
    end
  end

  assign sts.need_back = (func_r == csmac_pkg::FN_RSSI) &&
                         (acc_r == csmac_pkg::ACC_BUSY_PEND) && !busy_c;
  assign sts.need_draw = (func_r == csmac_pkg::FN_POLL) &&
                         (acc_r == csmac_pkg::ACC_IDLE_PEND) && expired_c;
  assign sts.div_done  = div_done;
  assign sts.draw_done = draw_v2_r;
  assign sts.draw_pass = (prob_r > draw_rem_r);

  always_comb begin
    acc_nxt     = acc_r;
    period_nxt  = period_r;
    elapsed_nxt = elapsed_r;
    tx_nxt      = tx_r;
    if (cmd.capture) begin
      tx_nxt = 1'b0;
    end
    if (cmd.apply) begin
      case (func_r)
        csmac_pkg::FN_RSSI: begin
          unique case (acc_r) inside
            csmac_pkg::ACC_INIT, csmac_pkg::ACC_BUSY, csmac_pkg::ACC_IDLE: begin
              acc_nxt = busy_c ? csmac_pkg::ACC_BUSY : csmac_pkg::ACC_IDLE;
            end
            csmac_pkg::ACC_IDLE_PEND: begin
              if (busy_c) acc_nxt = csmac_pkg::ACC_BUSY_PEND;
            end
            default: ;
          endcase
        end
        csmac_pkg::FN_POLL: begin
          if (acc_r == csmac_pkg::ACC_BUSY) begin
            acc_nxt = csmac_pkg::ACC_BUSY_PEND;
          end else if (acc_r == csmac_pkg::ACC_IDLE) begin
            tx_nxt = 1'b1;
          end
        end
        csmac_pkg::FN_TICK: begin
          if (elapsed_r != '1) elapsed_nxt = elapsed_r + 17'd1;
        end
        default: ;
      endcase
    end
    if (cmd.grant) begin
      acc_nxt = csmac_pkg::ACC_IDLE;
      tx_nxt  = 1'b1;
    end
    if (cmd.load_back) begin
      acc_nxt     = csmac_pkg::ACC_IDLE_PEND;
      elapsed_nxt = '0;
      period_nxt  = (hi_r < lo_r) ? lo_r : lo_r + rem[15:0];
    end
  end

  always_ff @(posedge clk) begin
    tx_r <= tx_nxt;
    if (!rst_n) begin
      acc_r     <= csmac_pkg::ACC_INIT;
      period_r  <= csmac_pkg::RST_WAIT_LO;
      elapsed_r <= '0;
    end else begin
      acc_r     <= acc_nxt;
      period_r  <= period_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  assign chan_busy_c = (acc_r == csmac_pkg::ACC_BUSY) ||
                       (acc_r == csmac_pkg::ACC_BUSY_PEND);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r <= {2'b00, acc_r, chan_busy_c,
                (func_r == csmac_pkg::FN_RSSI) && busy_c, tx_r};
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

@@ rtl/csmac_ctrl.sv @@
// Sequencer of the access controller: handshakes and command issue.
// Depends on csmac_pkg; drives csmac_dp through the command struct.
`default_nettype none

module csmac_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  input  wire csmac_pkg::csmac_sts_t sts,
  output csmac_pkg::csmac_cmd_t      cmd
);

  csmac_pkg::ctrl_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= csmac_pkg::C_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_tready     = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    unique case (state_r)
      csmac_pkg::C_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = csmac_pkg::C_EVAL;
        end
      end
      csmac_pkg::C_EVAL: begin
        if (sts.need_back) begin
          cmd.start_back = 1'b1;
          state_nxt      = csmac_pkg::C_BACK;
        end else if (sts.need_draw) begin
          cmd.start_draw = 1'b1;
          state_nxt      = csmac_pkg::C_DRAW;
        end else begin
          cmd.apply = 1'b1;
          state_nxt = csmac_pkg::C_DONE;
        end
      end
      csmac_pkg::C_DRAW: begin
        if (sts.draw_done) begin
          if (sts.draw_pass) begin
            cmd.grant = 1'b1;
            state_nxt = csmac_pkg::C_DONE;
          end else begin
            cmd.start_back = 1'b1;
            state_nxt      = csmac_pkg::C_BACK;
          end
        end
      end
      csmac_pkg::C_BACK: begin
        if (sts.div_done) begin
          cmd.load_back = 1'b1;
          state_nxt     = csmac_pkg::C_DONE;
        end
      end
      csmac_pkg::C_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = csmac_pkg::C_IDLE;
        end
      end
      default: state_nxt = csmac_pkg::C_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

@@ rtl/csma_access_controller_core.sv @@
// Top level of the carrier-sense medium access controller with p-persistent random backoff.
// Depends on csmac_pkg, csmac_ctrl, csmac_dp (and csmac_mod below it).
//
//   Channel  Direction  Word contents
//   in_      slave      tuser: func[1:0]; tdata: rssi, rand_draw, rand_backoff
//   out_     master     tdata: transmit_now, sample_busy, chan_busy, state_code
//   cfg_     write      index 0..3: busy level, send percentage, shortest and longest backoff
//
// A word without a random value is applied directly; a poll with expired backoff runs a
// probability draw, and a sample that frees the medium or a failed draw starts a backoff;
// the backoff span uses a remainder unit that takes one random bit per cycle.
// Reset is synchronous and active low; it restores register defaults, init and the timer.
// A finished word waits in the output register while the next one is accepted and worked
// on, and that next word holds in its last step until the register is free.
`default_nettype none

module csma_access_controller_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,  // [7:0] rssi, [22:8] rand_draw, [37:23] rand_backoff
  input  wire logic [1:0]  in_tuser,  // [1:0] func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata, // [0] transmit_now, [1] sample_busy,
                                      // [2] chan_busy, [5:3] state_code
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  csmac_pkg::csmac_cmd_t cmd;
  csmac_pkg::csmac_sts_t sts;

  // The sequencer owns both handshakes; the datapath only follows commands.
  csmac_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // The upper two data bits are byte padding and are not used.
  csmac_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_func         (in_tuser),
    .in_rssi         (in_tdata[7:0]),
    .in_rand_draw    (in_tdata[22:8]),
    .in_rand_backoff (in_tdata[37:23]),
    .cmd             (cmd),
    .sts             (sts),
    .out_data        (out_tdata)
  );

endmodule

`default_nettype wire
